### rtl/core/wtag_pkg.sv
// Shared types, register indexes and reset values for the wall texel address generator.
package wtag_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_TEXEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd4;

  localparam logic [12:0] RST_TEX_WIDTH       = 13'd64;
  localparam logic [12:0] RST_TEX_HEIGHT      = 13'd64;
  localparam logic [15:0] RST_ROW_PITCH       = 16'd256;
  localparam logic [3:0]  RST_BYTES_PER_TEXEL = 4'd4;
  localparam logic [12:0] RST_SCREEN_HEIGHT   = 13'd720;

  localparam logic [2:0] FACE_SOUTH = 3'd1;
  localparam logic [2:0] FACE_WEST  = 3'd2;
  localparam logic [2:0] FACE_EAST  = 3'd3;

  localparam int MAX_DIM_DEF         = 4096;
  localparam int MAX_SCREEN_ROWS_DEF = 4096;

  // Largest value a 13-bit size register can hold
  localparam int REG13_MAX = 8191;

  typedef struct packed {
    logic        ok;
    logic [11:0] buffer_index;
    logic [1:0]  texture_select;
    logic        ovf;
  } side_t;

endpackage

### rtl/core/wtag_front.sv
// Row test, fraction mirror, products and divider setup (three stages).
module wtag_front import wtag_pkg::*; #(
  parameter int DIM_W  = 13,
  parameter int ROWS_W = 13,
  parameter int RW     = 24 + DIM_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [11:0]            row,
  input  logic signed [15:0]     slice_start,
  input  logic signed [15:0]     wall_end,
  input  logic [15:0]            hit_fraction,
  input  logic [23:0]            wall_height_q8,
  input  logic [2:0]             face,
  input  logic [DIM_W-1:0]       w,
  input  logic [DIM_W-1:0]       h,
  input  logic [ROWS_W-1:0]      rows,
  output logic                   out_valid,
  input  logic                   out_ready,
  output side_t                  side,
  output logic [DIM_W-1:0]       tx,
  output logic [RW-1:0]          rem,
  output logic [RW-1:0]          dsh
);

  // stage 1
  logic signed [16:0] row_s, ws_s, we_s, start_s, off_d, bidx_d;
  logic               ok_d, mirror;
  logic               v1, rdy1;
  side_t              side1;
  logic [16:0]        fracm1;
  logic [15:0]        offset1;
  logic [23:0]        hq1;

  assign row_s   = signed'({5'b0, row});
  assign ws_s    = 17'(slice_start);
  assign we_s    = 17'(wall_end);
  assign start_s = (ws_s > 17'sd0) ? ws_s : 17'sd0;
  assign off_d   = row_s - ws_s;
  assign bidx_d  = row_s - start_s;
  assign mirror  = (face == FACE_SOUTH) || (face == FACE_WEST);
  assign ok_d    = (face <= FACE_EAST) && (row_s >= start_s) && (row_s <= we_s)
                   && (14'(row) < 14'(rows));

  // stage 2
  logic               v2, rdy2;
  side_t              side2;
  logic [16+DIM_W:0]  txp2;
  logic [15+DIM_W:0]  np2;
  logic [23:0]        hq2;

  // stage 3
  logic               v3, rdy3;
  logic [DIM_W:0]     txs;
  logic [RW-1:0]      num;
  logic [RW-1:0]      dfull;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      side1.ok             <= ok_d;
      side1.buffer_index   <= bidx_d[11:0];
      side1.texture_select <= face[1:0];
      side1.ovf            <= 1'b0;
      fracm1  <= mirror ? (17'h10000 - {1'b0, hit_fraction}) : {1'b0, hit_fraction};
      offset1 <= off_d[15:0];
      hq1     <= wall_height_q8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      side2 <= side1;
      txp2  <= (17+DIM_W)'(fracm1) * (17+DIM_W)'(w);
      np2   <= (16+DIM_W)'(offset1) * (16+DIM_W)'(h);
      hq2   <= hq1;
    end
  end

  assign txs   = txp2[16+DIM_W:16];
  assign num   = RW'({np2, 8'b0});
  assign dfull = RW'({hq2, DIM_W'(0)});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      side     <= side_t'({side2.ok, side2.buffer_index, side2.texture_select,
                           num >= dfull});
      tx       <= (txs >= (DIM_W+1)'(w)) ? (w - DIM_W'(1)) : txs[DIM_W-1:0];
      rem      <= num;
      dsh      <= RW'({hq2, (DIM_W-1)'(0)});
    end
  end

  assign out_valid = v3;

endmodule

### rtl/core/wtag_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the word on.
module wtag_div_cell import wtag_pkg::*; #(
  parameter int DIM_W = 13,
  parameter int RW    = 24 + DIM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  side_t            in_side,
  input  logic [DIM_W-1:0] in_tx,
  input  logic [RW-1:0]    in_rem,
  input  logic [RW-1:0]    in_dsh,
  input  logic [DIM_W-1:0] in_q,
  output logic             out_valid,
  input  logic             out_ready,
  output side_t            out_side,
  output logic [DIM_W-1:0] out_tx,
  output logic [RW-1:0]    out_rem,
  output logic [RW-1:0]    out_dsh,
  output logic [DIM_W-1:0] out_q
);

  logic v, take;

  assign take     = in_rem >= in_dsh;
  assign in_ready = !v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
    if (in_ready) begin
      out_side <= in_side;
      out_tx   <= in_tx;
      out_rem  <= take ? (in_rem - in_dsh) : in_rem;
      out_dsh  <= in_dsh >> 1;
      out_q    <= {in_q[DIM_W-2:0], take};
    end
  end

  assign out_valid = v;

endmodule

### rtl/core/wtag_back.sv
// Texture row clamp, address products and the output register.
module wtag_back import wtag_pkg::*; #(
  parameter int DIM_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  side_t            side,
  input  logic [DIM_W-1:0] tx,
  input  logic [DIM_W-1:0] q,
  input  logic [DIM_W-1:0] h,
  input  logic [15:0]      row_pitch,
  input  logic [3:0]       bytes_per_texel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             valid_res,
  output logic [11:0]      buffer_index,
  output logic [1:0]       texture_select,
  output logic [11:0]      tex_x,
  output logic [11:0]      tex_y,
  output logic [27:0]      texel_offset
);

  logic                v1, v2, v3, rdy1, rdy2, rdy3;
  side_t               side1, side2;
  logic [DIM_W-1:0]    tx1, ty1;
  logic [11:0]         tx2, ty2;
  logic [DIM_W+15:0]   pa2;
  logic [DIM_W+3:0]    pb2;
  logic [27:0]         sum;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      side1 <= side;
      tx1   <= tx;
      ty1   <= (side.ovf || q >= h) ? (h - DIM_W'(1)) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      side2 <= side1;
      tx2   <= 12'(tx1);
      ty2   <= 12'(ty1);
      pa2   <= (DIM_W+16)'(ty1) * (DIM_W+16)'(row_pitch);
      pb2   <= (DIM_W+4)'(tx1) * (DIM_W+4)'(bytes_per_texel);
    end
  end

  assign sum = 28'(pa2) + 28'(pb2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      valid_res      <= side2.ok;
      buffer_index   <= side2.ok ? side2.buffer_index : 12'd0;
      texture_select <= side2.ok ? side2.texture_select : 2'd0;
      tex_x          <= side2.ok ? tx2 : 12'd0;
      tex_y          <= side2.ok ? ty2 : 12'd0;
      texel_offset   <= side2.ok ? sum : 28'd0;
    end
  end

  assign out_valid = v3;

endmodule

### rtl/core/wall_texel_address_generator.sv
// Wall texel address generator: top level with registers and the divider chain.
//
// Input channel (in_valid/in_ready) takes one word per screen row of a wall
// slice; output channel (out_valid/out_ready) returns one word per input word,
// in order: valid flag, column buffer index, texture select, tex_x, tex_y and
// the texel byte offset. Rows outside the slice, off screen or with no face
// return a word with every field zero.
// Throughput: one word per cycle while out_ready is high. The pipeline has three
// front stages, one divider cell per texture row bit, and three back stages.
// The texture row quotient runs through a row of identical restoring cells,
// one quotient bit each; every stage has its own valid bit, so bubbles
// collapse and new words are taken while a finished word waits at the output.
// When the receiver stalls, words pile up stage by stage until the chain is
// full, then in_ready drops.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no word is in flight. cfg_ready is always high.
// Reset empties the pipeline and restores the register defaults.
module wall_texel_address_generator import wtag_pkg::*; #(
  parameter int MAX_DIM         = MAX_DIM_DEF,
  parameter int MAX_SCREEN_ROWS = MAX_SCREEN_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [11:0]          row,
  input  logic signed [15:0]   slice_start,
  input  logic signed [15:0]   wall_end,
  input  logic [15:0]          hit_fraction,
  input  logic [23:0]          wall_height_q8,
  input  logic [2:0]           face,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 valid_res,
  output logic [11:0]          buffer_index,
  output logic [1:0]           texture_select,
  output logic [11:0]          tex_x,
  output logic [11:0]          tex_y,
  output logic [27:0]          texel_offset,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int DIM_MAX  = (MAX_DIM > REG13_MAX) ? REG13_MAX : MAX_DIM;
  localparam int DIM_W    = $clog2(DIM_MAX + 1);
  localparam int ROWS_MAX = (MAX_SCREEN_ROWS > REG13_MAX) ? REG13_MAX : MAX_SCREEN_ROWS;
  localparam int ROWS_W   = $clog2(ROWS_MAX + 1);
  localparam int RW       = 24 + DIM_W;

  logic [12:0] tex_width, tex_height, screen_height;
  logic [15:0] row_pitch;
  logic [3:0]  bytes_per_texel;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [ROWS_W-1:0] rows_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width       <= RST_TEX_WIDTH;
      tex_height      <= RST_TEX_HEIGHT;
      row_pitch       <= RST_ROW_PITCH;
      bytes_per_texel <= RST_BYTES_PER_TEXEL;
      screen_height   <= RST_SCREEN_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:       tex_width       <= cfg_data[12:0];
        CFG_TEX_HEIGHT:      tex_height      <= cfg_data[12:0];
        CFG_ROW_PITCH:       row_pitch       <= cfg_data;
        CFG_BYTES_PER_TEXEL: bytes_per_texel <= cfg_data[3:0];
        CFG_SCREEN_HEIGHT:   screen_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(tex_width) > 32'(DIM_MAX)) begin
      w_eff = DIM_W'(DIM_MAX);
    end else if (tex_width == 13'd0) begin
      w_eff = DIM_W'(1);
    end else begin
      w_eff = DIM_W'(tex_width);
    end
    if (32'(tex_height) > 32'(DIM_MAX)) begin
      h_eff = DIM_W'(DIM_MAX);
    end else if (tex_height == 13'd0) begin
      h_eff = DIM_W'(1);
    end else begin
      h_eff = DIM_W'(tex_height);
    end
    if (32'(screen_height) > 32'(ROWS_MAX)) begin
      rows_eff = ROWS_W'(ROWS_MAX);
    end else begin
      rows_eff = ROWS_W'(screen_height);
    end
  end

  logic             c_valid [DIM_W+1];
  logic             c_ready [DIM_W+1];
  side_t            c_side  [DIM_W+1];
  logic [DIM_W-1:0] c_tx    [DIM_W+1];
  logic [RW-1:0]    c_rem   [DIM_W+1];
  logic [RW-1:0]    c_dsh   [DIM_W+1];
  logic [DIM_W-1:0] c_q     [DIM_W+1];

  wtag_front #(
    .DIM_W  (DIM_W),
    .ROWS_W (ROWS_W),
    .RW     (RW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .row            (row),
    .slice_start    (slice_start),
    .wall_end       (wall_end),
    .hit_fraction   (hit_fraction),
    .wall_height_q8 (wall_height_q8),
    .face           (face),
    .w              (w_eff),
    .h              (h_eff),
    .rows           (rows_eff),
    .out_valid      (c_valid[0]),
    .out_ready      (c_ready[0]),
    .side           (c_side[0]),
    .tx             (c_tx[0]),
    .rem            (c_rem[0]),
    .dsh            (c_dsh[0])
  );

  assign c_q[0] = '0;

  for (genvar i = 0; i < DIM_W; i++) begin : g_cell
    wtag_div_cell #(
      .DIM_W (DIM_W),
      .RW    (RW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_side   (c_side[i]),
      .in_tx     (c_tx[i]),
      .in_rem    (c_rem[i]),
      .in_dsh    (c_dsh[i]),
      .in_q      (c_q[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_side  (c_side[i+1]),
      .out_tx    (c_tx[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_dsh   (c_dsh[i+1]),
      .out_q     (c_q[i+1])
    );
  end

  wtag_back #(
    .DIM_W (DIM_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (c_valid[DIM_W]),
    .in_ready        (c_ready[DIM_W]),
    .side            (c_side[DIM_W]),
    .tx              (c_tx[DIM_W]),
    .q               (c_q[DIM_W]),
    .h               (h_eff),
    .row_pitch       (row_pitch),
    .bytes_per_texel (bytes_per_texel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .valid_res       (valid_res),
    .buffer_index    (buffer_index),
    .texture_select  (texture_select),
    .tex_x           (tex_x),
    .tex_y           (tex_y),
    .texel_offset    (texel_offset)
  );

`ifndef SYNTHESIS
  a_blank_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> texel_offset == 28'd0 && tex_x == 12'd0 &&
      tex_y == 12'd0 && buffer_index == 12'd0 && texture_select == 2'd0)
    else $error("dropped row carries nonzero fields");

  a_tex_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> 14'(tex_y) < 14'(h_eff) && 14'(tex_x) < 14'(w_eff))
    else $error("texture coordinate outside texture");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    c_valid[DIM_W] && !c_ready[DIM_W] |=> c_valid[DIM_W] && $stable(c_q[DIM_W]))
    else $error("divider output lost while back end stalled");
`endif

endmodule

### tb/wall_texel_address_generator_test.sv
// Self-checking testbench for the wall texel address generator.
module wall_texel_address_generator_test import wtag_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FACE_NORTH = 3'd0;
  localparam logic [2:0] FACE_NONE = 3'd4;
  localparam logic [2:0] FACE_NONE_LAST = 3'd7;
  localparam longint ONE_Q16 = 65536;
  localparam int LATENCY = 19;

  typedef struct {
    logic [11:0] row;
    logic signed [15:0] slice_start;
    logic signed [15:0] wall_end;
    logic [15:0] hit_fraction;
    logic [23:0] wall_height_q8;
    logic [2:0] face;
  } span_row_t;

  typedef struct {
    logic valid_res;
    logic [11:0] buffer_index;
    logic [1:0] texture_select;
    logic [11:0] tex_x;
    logic [11:0] tex_y;
    logic [27:0] texel_offset;
  } texel_addr_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] row = '0;
  logic signed [15:0] slice_start = '0;
  logic signed [15:0] wall_end = '0;
  logic [15:0] hit_fraction = '0;
  logic [23:0] wall_height_q8 = '0;
  logic [2:0] face = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic valid_res;
  logic [11:0] buffer_index;
  logic [1:0] texture_select;
  logic [11:0] tex_x;
  logic [11:0] tex_y;
  logic [27:0] texel_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [12:0] cur_tex_width = RST_TEX_WIDTH;
  logic [12:0] cur_tex_height = RST_TEX_HEIGHT;
  logic [15:0] cur_row_pitch = RST_ROW_PITCH;
  logic [3:0] cur_bytes_per_texel = RST_BYTES_PER_TEXEL;
  logic [12:0] cur_screen_height = RST_SCREEN_HEIGHT;

  texel_addr_t pending_texels[$];
  int errors = 0;
  bit quiet = 1'b0;
  int ready_hold = 0;

  wall_texel_address_generator dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint texture_dim(logic [12:0] v);
    longint d;
    d = (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
    return (d == 0) ? 1 : d;
  endfunction

  function automatic int drawn_rows();
    return (cur_screen_height > MAX_SCREEN_ROWS_DEF) ? MAX_SCREEN_ROWS_DEF :
           int'(cur_screen_height);
  endfunction

  function automatic texel_addr_t predict_texel(span_row_t s);
    texel_addr_t t;
    longint r, ws, we, start, wd, ht, frac, tx, ty;
    t = '{default: '0};
    r = s.row;
    ws = s.slice_start;
    we = s.wall_end;
    start = (ws > 0) ? ws : 0;
    wd = texture_dim(cur_tex_width);
    ht = texture_dim(cur_tex_height);
    if (s.face > FACE_EAST || r < start || r > we || r >= drawn_rows()) return t;
    frac = s.hit_fraction;
    if (s.face == FACE_SOUTH || s.face == FACE_WEST) frac = ONE_Q16 - frac;
    tx = (frac * wd) >> 16;
    if (tx >= wd) tx = wd - 1;
    if (s.wall_height_q8 == 0) begin
      ty = ht - 1;
    end else begin
      ty = ((r - ws) * ht * 256) / longint'(s.wall_height_q8);
      if (ty >= ht) ty = ht - 1;
    end
    t.valid_res = 1'b1;
    t.buffer_index = 12'(r - start);
    t.texture_select = s.face[1:0];
    t.tex_x = 12'(tx);
    t.tex_y = 12'(ty);
    t.texel_offset = 28'(ty * longint'(cur_row_pitch) + tx * longint'(cur_bytes_per_texel));
    return t;
  endfunction

  function automatic span_row_t make_row(int r, int ws, int we, int frac, int hq8,
                                         logic [2:0] f);
    span_row_t s;
    s.row = 12'(r);
    s.slice_start = 16'(ws);
    s.wall_end = 16'(we);
    s.hit_fraction = 16'(frac);
    s.wall_height_q8 = 24'(hq8);
    s.face = f;
    return s;
  endfunction

  function automatic span_row_t random_span_row();
    span_row_t s;
    int n, lo, hi, r_lo, r_hi;
    n = drawn_rows();
    if (n == 0 || $urandom_range(0, 4) == 0) begin
      s.row = 12'($urandom);
      s.slice_start = 16'($urandom);
      s.wall_end = 16'($urandom);
      s.hit_fraction = 16'($urandom);
      s.wall_height_q8 = 24'($urandom);
      s.face = 3'($urandom);
      return s;
    end
    if ($urandom_range(0, 3) == 0) lo = -int'($urandom_range(0, 32768));
    else lo = $urandom_range(0, n - 1);
    hi = lo + int'($urandom_range(0, (lo < 0) ? 40000 : 3000));
    if (hi > 32767) hi = 32767;
    r_lo = (lo < 0) ? 0 : lo;
    r_hi = (hi < n - 1) ? hi : n - 1;
    if (r_hi < r_lo) r_hi = r_lo;
    s.row = 12'($urandom_range(r_lo, r_hi));
    s.slice_start = 16'(lo);
    s.wall_end = 16'(hi);
    s.hit_fraction = 16'($urandom);
    case ($urandom_range(0, 9))
      0: s.wall_height_q8 = '0;
      1: s.wall_height_q8 = 24'($urandom);
      2: s.wall_height_q8 = 24'($urandom_range(1, 255));
      default: s.wall_height_q8 = 24'((hi - lo + 1) * 256 + int'($urandom_range(0, 511)));
    endcase
    if ($urandom_range(0, 9) == 0) s.face = 3'($urandom_range(FACE_NONE, FACE_NONE_LAST));
    else s.face = 3'($urandom_range(FACE_NORTH, FACE_EAST));
    return s;
  endfunction

  task automatic send_row(span_row_t s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    row <= s.row;
    slice_start <= s.slice_start;
    wall_end <= s.wall_end;
    hit_fraction <= s.hit_fraction;
    wall_height_q8 <= s.wall_height_q8;
    face <= s.face;
    do @(posedge clk); while (!in_ready);
    pending_texels.push_back(predict_texel(s));
  endtask

  task automatic send_random_rows(int count);
    repeat (count) send_row(random_span_row());
  endtask

  task automatic wait_all_texels();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_texels.size() != 0);
  endtask

  task automatic program_texture(int w, int h, int pitch, int bpt, int screen);
    logic [CFG_IDX_W-1:0] idx[5];
    int vals[5];
    idx = '{CFG_TEX_WIDTH, CFG_TEX_HEIGHT, CFG_ROW_PITCH, CFG_BYTES_PER_TEXEL,
            CFG_SCREEN_HEIGHT};
    vals = '{w, h, pitch, bpt, screen};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= 16'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_TEX_WIDTH: cur_tex_width = 13'(vals[i]);
        CFG_TEX_HEIGHT: cur_tex_height = 13'(vals[i]);
        CFG_ROW_PITCH: cur_row_pitch = 16'(vals[i]);
        CFG_BYTES_PER_TEXEL: cur_bytes_per_texel = 4'(vals[i]);
        default: cur_screen_height = 13'(vals[i]);
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    texel_addr_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_texels.size() == 0) begin
        errors++;
        $display("%0t: word expected none actual tex_x %0h tex_y %0h", $time, tex_x, tex_y);
      end else begin
        want = pending_texels.pop_front();
        check_field("valid_res", want.valid_res, valid_res);
        check_field("buffer_index", want.buffer_index, buffer_index);
        check_field("texture_select", want.texture_select, texture_select);
        check_field("tex_x", want.tex_x, tex_x);
        check_field("tex_y", want.tex_y, tex_y);
        check_field("texel_offset", want.texel_offset, texel_offset);
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_face_and_clip_cases();
    send_row(make_row(0, 0, 100, 0, 25600, FACE_NORTH));
    send_row(make_row(0, 0, 100, 0, 25600, FACE_SOUTH));
    send_row(make_row(50, 0, 100, 16'hFFFF, 25600, FACE_WEST));
    send_row(make_row(100, 0, 100, 16'hFFFF, 25600, FACE_EAST));
    send_row(make_row(10, 0, 100, 1234, 25600, FACE_NONE));
    send_row(make_row(10, 0, 100, 1234, 25600, FACE_NONE_LAST));
    send_row(make_row(5, 10, 100, 4321, 25600, FACE_NORTH));
    send_row(make_row(101, 0, 100, 4321, 25600, FACE_EAST));
    send_row(make_row(720, 0, 32767, 999, 25600, FACE_NORTH));
    send_row(make_row(719, 0, 32767, 999, 24'hFFFFFF, FACE_SOUTH));
    send_row(make_row(30, 0, 100, 16'h8000, 0, FACE_EAST));
    send_row(make_row(0, -32768, 32767, 16'h1234, 25600, FACE_WEST));
    send_row(make_row(5, -100, -1, 16'h4000, 25600, FACE_NORTH));
    send_row(make_row(4095, 0, 32767, 16'h4000, 25600, FACE_NORTH));
    wait_all_texels();
  endtask

  task automatic test_register_extremes();
    program_texture(4096, 4096, 65535, 8, 4096);
    send_row(make_row(4095, 0, 32767, 0, 256, FACE_SOUTH));
    send_row(make_row(4095, 4095, 4095, 16'hFFFF, 24'hFFFFFF, FACE_NORTH));
    send_random_rows(100);
    wait_all_texels();
    program_texture(1, 1, 1, 0, 1);
    send_random_rows(60);
    wait_all_texels();
    program_texture(8191, 0, 0, 15, 8191);
    send_random_rows(100);
    wait_all_texels();
    program_texture(0, 8191, 65535, 1, 0);
    send_random_rows(40);
    wait_all_texels();
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      program_texture(int'($urandom_range(0, 7) << 13) + int'($urandom_range(1, 300)),
                      int'($urandom_range(0, 7) << 13) + int'($urandom_range(1, 300)),
                      $urandom_range(1, 65535), $urandom_range(0, 15),
                      int'($urandom_range(0, 7) << 13) + int'($urandom_range(1, 4096)));
      send_random_rows(100);
      wait_all_texels();
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    program_texture($urandom_range(1, 4096), $urandom_range(1, 4096),
                    $urandom_range(1, 65535), $urandom_range(1, 8), $urandom_range(1, 4096));
    send_random_rows(150);
    wait_all_texels();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_face_and_clip_cases();
    test_register_extremes();
    test_random_settings();
    test_back_to_back();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && pending_texels.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
